// File: hdl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants, codes and controller/datapath signal groups for the
// min-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 7;

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STAT_W-1:0] ST_EXTRACTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic ins;
		logic rej_full;
		logic rej_empty;
		logic scan_start;
		logic scan_step;
		logic commit;
		logic load_out;
	} mpq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
	} mpq_sts_t;

endpackage

// File: hdl/mpq_req_if.sv
// ----------------------------------------------------------------------------
// mpq_req_if
// Request channel: one insert or extract transaction.
// ----------------------------------------------------------------------------
interface mpq_req_if import mpq_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic signed [KEY_W-1:0] key_in;

	modport source (output valid, output cmd, output key_in, input ready);
	modport sink (input valid, input cmd, input key_in, output ready);

endinterface

// File: hdl/mpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mpq_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface mpq_rsp_if import mpq_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic signed [KEY_W-1:0] key_out;
	logic [STAT_W-1:0]       status;
	logic [OCC_W-1:0]        occupancy;

	modport source (output valid, output key_out, output status, output occupancy,
		input ready);
	modport sink (input valid, input key_out, input status, input occupancy,
		output ready);

endinterface

// File: hdl/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for the queue: accepts a request, runs insert or the extract
// scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mpq_ctrl import mpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_cmd,
	output logic     req_ready,
	input  logic     rsp_ready,
	output logic     rsp_valid,
	input  mpq_sts_t sts,
	output mpq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DONE;
					if (req_cmd == CMD_INSERT) begin
						if (sts.full) cmd.rej_full = 1'b1;
						else cmd.ins = 1'b1;
					end else if (sts.empty) begin
						cmd.rej_empty = 1'b1;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten while stalled");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !sts.empty)
		else $error("extract scan started on empty queue");

	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == S_DONE))
		else $error("commit not followed by result hand-off");

endmodule

// File: hdl/mpq_dp.sv
// ----------------------------------------------------------------------------
// mpq_dp
// Datapath: key memory, occupancy count, minimum scan and result register.
// ----------------------------------------------------------------------------
module mpq_dp import mpq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [KEY_W-1:0] key_in,
	input  mpq_cmd_t                cmd,
	output mpq_sts_t                sts,
	output logic signed [KEY_W-1:0] key_out,
	output logic [STAT_W-1:0]       status,
	output logic [OCC_W-1:0]        occupancy
);

	logic signed [KEY_W-1:0] mem [CAPACITY];

	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        rd_idx_q;
	logic signed [KEY_W-1:0] rdata_q;
	logic signed [KEY_W-1:0] best_key_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic signed [KEY_W-1:0] last_key_q;
	logic signed [KEY_W-1:0] res_key_q;
	logic [STAT_W-1:0]       res_status_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [STAT_W-1:0]       out_status_q;
	logic [OCC_W-1:0]        out_occ_q;

	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic signed [KEY_W-1:0] wr_data;
	logic                    take_new;

	assign sts.full      = (count_q == CNT_W'(CAPACITY));
	assign sts.empty     = (count_q == '0);
	assign sts.scan_last = (rd_idx_q == IDX_W'(count_q - CNT_W'(1)));

	assign rd_en   = cmd.scan_start || (cmd.scan_step && !sts.scan_last);
	assign rd_addr = cmd.scan_start ? '0 : IDX_W'(rd_idx_q + IDX_W'(1));
	assign wr_en   = cmd.ins || cmd.commit;
	assign wr_addr = cmd.ins ? IDX_W'(count_q) : best_idx_q;
	assign wr_data = cmd.ins ? key_in : last_key_q;

	assign take_new = (rd_idx_q == '0) || (rdata_q < best_key_q);

	assign key_out   = out_key_q;
	assign status    = out_status_q;
	assign occupancy = out_occ_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.commit) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_idx_q <= rd_addr;
		if (cmd.scan_step) begin
			if (take_new) begin
				best_key_q <= rdata_q;
				best_idx_q <= rd_idx_q;
			end
			if (sts.scan_last) last_key_q <= rdata_q;
		end
		priority if (cmd.ins) begin
			res_key_q    <= '0;
			res_status_q <= ST_INSERTED;
		end else if (cmd.rej_full) begin
			res_key_q    <= '0;
			res_status_q <= ST_FULL;
		end else if (cmd.rej_empty) begin
			res_key_q    <= '0;
			res_status_q <= ST_EMPTY;
		end else if (cmd.commit) begin
			res_key_q    <= best_key_q;
			res_status_q <= ST_EXTRACTED;
		end
		if (cmd.load_out) begin
			out_key_q    <= res_key_q;
			out_status_q <= res_status_q;
			out_occ_q    <= OCC_W'(count_q);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("occupancy exceeds capacity");

	a_commit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("extract did not decrement occupancy");

endmodule

// File: hdl/min_priority_queue.sv
// ----------------------------------------------------------------------------
// min_priority_queue
// Bounded min-priority queue over signed 32-bit keys.
//
// The req channel carries cmd (insert or extract) and key_in; each request
// transaction yields exactly one rsp transaction with key_out, status and
// occupancy. Keys sit unordered in a single-port-write, registered-read
// memory of CAPACITY entries; an extract reads every stored key once,
// keeps the smallest, and moves the last stored key into the freed slot.
// Insert, rejected insert and empty extract pass from IDLE straight to
// DONE; an extract runs the SCAN state, one entry per cycle through the
// memory read port, and then COMMIT before it reaches DONE.
// A new request is accepted once the previous one has reached the result
// register, so the next request may enter while a result is still held.
// When the receiver stalls, the result holds in the output register and
// the block stops after finishing at most one more request.
// Reset clears the occupancy count and all handshake state; memory
// contents need no clearing, since only written entries are ever read.
// ----------------------------------------------------------------------------
module min_priority_queue import mpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	mpq_req_if.sink     req,
	mpq_rsp_if.source   rsp
);

	mpq_cmd_t cmd;
	mpq_sts_t sts;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (req.key_in),
		.cmd       (cmd),
		.sts       (sts),
		.key_out   (rsp.key_out),
		.status    (rsp.status),
		.occupancy (rsp.occupancy)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for min_priority_queue. Sends insert and extract
// transactions on the request channel, predicts every response from a
// bag of held keys, and checks each response field by field in order.
// Covers empty extract, full insert, signed ordering, extreme and duplicate
// keys, fill/flush rounds and random traffic with idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb;
	import mpq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = CAPACITY + 16;

	typedef struct {
		logic signed [KEY_W-1:0] key;
		logic [STAT_W-1:0]       status;
		logic [OCC_W-1:0]        occupancy;
	} mpq_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mpq_req_if req_ch ();
	mpq_rsp_if rsp_ch ();

	min_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic signed [KEY_W-1:0] held_keys[$];
	mpq_result_t             pending_results[$];
	int                      mismatch_count = 0;
	int                      quiet_cycles = 0;
	int                      stall_left = 0;
	bit                      idle_on = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Apply one accepted request to the held keys and queue its response.
	task automatic apply_request(input logic cmd, input logic signed [KEY_W-1:0] key);
		mpq_result_t r;
		int          best;
		r.key    = '0;
		if (cmd == CMD_INSERT) begin
			if (held_keys.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				held_keys.push_back(key);
				r.status = ST_INSERTED;
			end
		end else begin
			if (held_keys.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				best = 0;
				for (int i = 1; i < held_keys.size(); i++)
					if (held_keys[i] < held_keys[best])
						best = i;
				r.key = held_keys[best];
				held_keys.delete(best);
				r.status = ST_EXTRACTED;
			end
		end
		r.occupancy = OCC_W'(held_keys.size());
		pending_results.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			apply_request(req_ch.cmd, req_ch.key_in);
	end

	always @(posedge clk) begin
		mpq_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected response key %0d status %0d occ %0d",
					rsp_ch.key_out, rsp_ch.status, rsp_ch.occupancy));
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.key_out !== want.key)
					report_mismatch($sformatf("key_out %0d, want %0d",
						rsp_ch.key_out, want.key));
				if (rsp_ch.occupancy !== want.occupancy)
					report_mismatch($sformatf("occupancy %0d, want %0d",
						rsp_ch.occupancy, want.occupancy));
			end
		end
	end

	// Stall the response channel in random bursts while idle_on is set.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input logic cmd, input logic signed [KEY_W-1:0] key);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			req_ch.valid  <= 1'b0;
			req_ch.cmd    <= 1'($urandom_range(0, 1));
			req_ch.key_in <= $urandom;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.cmd    <= cmd;
		req_ch.key_in <= key;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_mix(input int count, input int insert_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < insert_pct)
				send_request(CMD_INSERT, pick_key());
			else
				send_request(CMD_EXTRACT, $urandom);
		end
	endtask

	task automatic test_empty_extract();
		send_request(CMD_EXTRACT, 32'sh7FFF_FFFF);
		send_request(CMD_EXTRACT, '0);
	endtask

	task automatic test_signed_order();
		send_request(CMD_INSERT, 32'sh7FFF_FFFF);
		send_request(CMD_INSERT, 32'sh8000_0000);
		send_request(CMD_INSERT, 0);
		send_request(CMD_INSERT, -1);
		send_request(CMD_INSERT, 1);
		repeat (5) send_request(CMD_EXTRACT, '0);
		send_request(CMD_EXTRACT, '1);
	endtask

	task automatic test_largest_duplicates();
		repeat (3) send_request(CMD_INSERT, 32'sh7FFF_FFFF);
		send_request(CMD_INSERT, 32'shAAAA_AAAA);
		send_request(CMD_INSERT, 32'sh5555_5555);
		repeat (5) send_request(CMD_EXTRACT, '0);
	endtask

	task automatic test_fill_flush();
		for (int round = 0; round < 4; round++) begin
			idle_on = (round != 1);
			while (held_keys.size() < CAPACITY) send_mix(1, 85);
			send_mix(6, 100);
			while (held_keys.size() > 0) send_mix(1, 15);
			send_mix(4, 0);
		end
	endtask

	task automatic test_random_mix();
		for (int block = 0; block < 6; block++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			send_mix(100, $urandom_range(35, 65));
		end
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		send_mix(150, 60);
		send_mix(150, 40);
	endtask

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.cmd    = CMD_INSERT;
		req_ch.key_in = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		idle_on = 1'b1;
		test_empty_extract();
		test_signed_order();
		test_largest_duplicates();
		wait_drained();
		test_fill_flush();
		wait_drained();
		test_random_mix();
		test_back_to_back();

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
